### rtl/core/isim_pkg.sv
package isim_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int SLOT_W        = 4;
  localparam int VAL_W         = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } ent_t;

  // per-cell flags handed to neighbours
  typedef struct packed {
    logic aa;  // at or after insert point
    logic g;   // occupied and hi >= new start
    logic ov;  // occupied and overlaps new interval
  } flags_t;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_ROTATE,
    MODE_INSERT,
    MODE_COLLAPSE,
    MODE_ABSORB
  } mode_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [VAL_W-1:0] s;
    logic signed [VAL_W-1:0] e;
  } ctl_t;

endpackage

### rtl/core/isim_cell.sv
module isim_cell
  import isim_pkg::*;
(
  input  logic   clk,
  input  ctl_t   ctl,
  input  logic   occ,
  input  flags_t left_fl,
  input  flags_t right_fl,
  input  ent_t   left_ent,
  input  ent_t   right_ent,
  output ent_t   ent,
  output flags_t fl,
  output logic   head
);

  ent_t ent_next;
  logic ge;
  logic le;

  always_comb begin
    ge      = ent.hi >= ctl.s;
    le      = ent.lo <= ctl.e;
    fl.g    = occ & ge;
    fl.aa   = ~occ | ge;
    fl.ov   = occ & ge & le;
    // first of an overlapping run that still has a successor in the run
    head    = fl.ov & ~left_fl.ov & right_fl.ov;
  end

  always_comb begin
    ent_next = ent;
    case (ctl.mode)
      MODE_HOLD: begin
        ent_next = ent;
      end
      MODE_ROTATE: begin
        ent_next = right_ent;
      end
      MODE_INSERT: begin
        if (fl.aa && !left_fl.aa) begin
          ent_next.lo = ctl.s;
          ent_next.hi = ctl.e;
        end else if (fl.aa) begin
          ent_next = left_ent;
        end
      end
      MODE_COLLAPSE: begin
        if (head) begin
          ent_next.hi = right_ent.hi;
        end else if (left_fl.g) begin
          ent_next = right_ent;
        end
      end
      MODE_ABSORB: begin
        if (fl.ov) begin
          ent_next.lo = (ctl.s < ent.lo) ? ctl.s : ent.lo;
          ent_next.hi = (ctl.e > ent.hi) ? ctl.e : ent.hi;
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

### rtl/core/interval_set_insert_merge.sv
// Sorted set of up to TABLE_DEPTH disjoint closed intervals, kept in a row of cells, one
// interval per cell. A request is taken only when the block is idle; start and end are
// swapped if given reversed. The new interval is folded into the table one stored entry
// per cycle, then the whole table is emitted in order by rotating the row once round,
// pausing under output back-pressure. Results carry slot (position modulo 16),
// last_of_run on the final entry, and overflow on every result of a request dropped
// because the table was full.
module interval_set_insert_merge
  import isim_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] new_start,
  input  logic signed [VAL_W-1:0] new_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] seg_start,
  output logic signed [VAL_W-1:0] seg_end,
  output logic [SLOT_W-1:0]       slot,
  output logic                    last_of_run,
  output logic                    overflow
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MERGE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [IDX_W-1:0]        idx;
  logic                    ovf;
  logic signed [VAL_W-1:0] req_s;
  logic signed [VAL_W-1:0] req_e;

  ctl_t                    ctl;
  ent_t                    cell_ent [TABLE_DEPTH];
  flags_t                  cell_fl  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  head_vec;
  logic [TABLE_DEPTH-1:0]  ov_vec;
  logic [TABLE_DEPTH-1:0]  occ_vec;

  logic                    any_head;
  logic                    any_ov;
  logic                    emit_live;
  logic                    step;
  logic [IDX_W+SLOT_W-1:0] idx_wide;

  assign in_ready  = (state == ST_IDLE);
  assign any_head  = |head_vec;
  assign any_ov    = |ov_vec;
  assign emit_live = CNT_W'(idx) < cnt;
  assign step      = (state == ST_EMIT) && (!emit_live || !out_valid || out_ready);
  assign idx_wide  = {{SLOT_W{1'b0}}, idx};

  always_comb begin
    ctl.s    = req_s;
    ctl.e    = req_e;
    ctl.mode = MODE_HOLD;
    if (state == ST_MERGE) begin
      if (any_head) begin
        ctl.mode = MODE_COLLAPSE;
      end else if (any_ov) begin
        ctl.mode = MODE_ABSORB;
      end else if (cnt != FULL) begin
        ctl.mode = MODE_INSERT;
      end
    end else if (step) begin
      ctl.mode = MODE_ROTATE;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    flags_t lf;
    flags_t rf;
    ent_t   le;
    ent_t   re;

    assign occ_vec[i] = cnt > CNT_W'(i);

    if (i == 0) begin : g_first
      assign lf = '0;
      assign le = cell_ent[TABLE_DEPTH-1];
    end else begin : g_mid_l
      assign lf = cell_fl[i-1];
      assign le = cell_ent[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign rf = '0;
      assign re = cell_ent[0];
    end else begin : g_mid_r
      assign rf = cell_fl[i+1];
      assign re = cell_ent[i+1];
    end

    assign ov_vec[i] = cell_fl[i].ov;

    isim_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_vec[i]),
      .left_fl   (lf),
      .right_fl  (rf),
      .left_ent  (le),
      .right_ent (re),
      .ent       (cell_ent[i]),
      .fl        (cell_fl[i]),
      .head      (head_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      idx       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step && emit_live) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ovf   <= 1'b0;
            state <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          idx <= '0;
          if (any_head) begin
            cnt <= cnt - CNT_W'(1);
          end else begin
            state <= ST_EMIT;
            if (!any_ov) begin
              if (cnt == FULL) begin
                ovf <= 1'b1;
              end else begin
                cnt <= cnt + CNT_W'(1);
              end
            end
          end
        end
        ST_EMIT: begin
          if (step) begin
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_s <= (new_start > new_end) ? new_end : new_start;
      req_e <= (new_start > new_end) ? new_start : new_end;
    end
    if (step && emit_live) begin
      seg_start   <= cell_ent[0].lo;
      seg_end     <= cell_ent[0].hi;
      slot        <= idx_wide[SLOT_W-1:0];
      last_of_run <= (CNT_W'(idx) + CNT_W'(1)) == cnt;
      overflow    <= ovf;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL)
    else $error("entry count beyond table depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (cnt == FULL))
    else $error("overflow flagged on a table that is not full");

  a_emit_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |=> $stable(cnt))
    else $error("entry count changed while emitting");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (cnt != '0))
    else $error("table empty after a request");

endmodule

### verif/tb_top.sv
module tb_top;
  import isim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam longint VMIN_L = -(longint'(1) << (VAL_W-1));
  localparam longint VMAX_L = (longint'(1) << (VAL_W-1)) - 1;
  localparam int N_RAND = 480;
  localparam int N_DIR = 24;

  typedef struct packed {
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [SLOT_W-1:0]       pos;
    logic                    last;
    logic                    ovf;
  } seg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    typed;
    logic signed [VAL_W-1:0] t_lo;
    logic signed [VAL_W-1:0] t_hi;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pat_e;
  typedef enum logic [1:0] {TOUCH_BELOW, TOUCH_ABOVE, TOUCH_INSIDE} touch_e;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] new_start = '0;
  logic signed [VAL_W-1:0] new_end = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] seg_start;
  logic signed [VAL_W-1:0] seg_end;
  logic [SLOT_W-1:0]       slot;
  logic                    last_of_run;
  logic                    overflow;

  // mirror of the interval table
  logic signed [VAL_W-1:0] set_lo [DEPTH];
  logic signed [VAL_W-1:0] set_hi [DEPTH];
  int                      set_cnt = 0;
  seg_t                    expected_segs [$];

  int      err_cnt = 0;
  int      n_reqs = 0;
  int      n_merged = 0;
  int      n_dropped = 0;
  int      n_segs = 0;
  int      peak_cnt = 0;
  int      burst_left = 1;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      pat_left = 0;
  int      phase = 0;
  rx_pat_e rx_pat = RX_OPEN;

  // touching, reversed, extremes, full table with drop, multi-entry absorb
  dir_row_t dir_rows [N_DIR] = '{
    '{100, 200, 1'b1, 100, 200},
    '{300, 400, 1'b0, 0, 0},
    '{200, 250, 1'b0, 0, 0},
    '{450, 400, 1'b0, 0, 0},
    '{VMIN, VMIN, 1'b0, 0, 0},
    '{VMAX, VMAX, 1'b0, 0, 0},
    '{1000, 1005, 1'b0, 0, 0},
    '{2000, 2005, 1'b0, 0, 0},
    '{3000, 3005, 1'b0, 0, 0},
    '{4000, 4005, 1'b0, 0, 0},
    '{5000, 5005, 1'b0, 0, 0},
    '{6000, 6005, 1'b0, 0, 0},
    '{7000, 7005, 1'b0, 0, 0},
    '{8000, 8005, 1'b0, 0, 0},
    '{9000, 9005, 1'b0, 0, 0},
    '{10000, 10005, 1'b0, 0, 0},
    '{11000, 11005, 1'b0, 0, 0},
    '{12000, 12005, 1'b0, 0, 0},
    '{50, 60, 1'b0, 0, 0},
    '{VMAX - 1, VMAX, 1'b0, 0, 0},
    '{VMIN, VMIN + 7, 1'b0, 0, 0},
    '{250, 300, 1'b0, 0, 0},
    '{3000, 6005, 1'b0, 0, 0},
    '{-7, -9, 1'b0, 0, 0}
  };

  interval_set_insert_merge u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .new_start   (new_start),
    .new_end     (new_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .seg_start   (seg_start),
    .seg_end     (seg_end),
    .slot        (slot),
    .last_of_run (last_of_run),
    .overflow    (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void expect_seg(input seg_t sg);
    expected_segs.insert(expected_segs.size(), sg);
  endfunction

  function automatic void insert_interval(input logic signed [VAL_W-1:0] a, b,
                                          input bit push);
    logic signed [VAL_W-1:0] lo, hi;
    int   first, last, gone, i;
    bit   dropped;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    first = -1;
    last = -1;
    dropped = 1'b0;
    for (i = 0; i < set_cnt; i++) begin
      if (first < 0 && set_hi[i] >= lo) first = i;
      if (set_lo[i] <= hi) last = i;
    end
    if (first < 0) first = set_cnt;
    if (first <= last) begin
      if (set_lo[first] < lo) lo = set_lo[first];
      if (set_hi[last] > hi) hi = set_hi[last];
      gone = last - first;
      set_lo[first] = lo;
      set_hi[first] = hi;
      for (i = first + 1; i + gone < set_cnt; i++) begin
        set_lo[i] = set_lo[i + gone];
        set_hi[i] = set_hi[i + gone];
      end
      set_cnt -= gone;
      n_merged++;
    end else if (set_cnt >= DEPTH) begin
      dropped = 1'b1;
      n_dropped++;
    end else begin
      for (i = set_cnt; i > first; i--) begin
        set_lo[i] = set_lo[i - 1];
        set_hi[i] = set_hi[i - 1];
      end
      set_lo[first] = lo;
      set_hi[first] = hi;
      set_cnt++;
    end
    if (set_cnt > peak_cnt) peak_cnt = set_cnt;
    if (push) begin
      for (i = 0; i < set_cnt; i++)
        expect_seg('{set_lo[i], set_hi[i], SLOT_W'(i), (i == set_cnt - 1), dropped});
    end
  endfunction

  function automatic longint rand_below(input longint n);
    return longint'({$urandom, $urandom} % n);
  endfunction

  // mostly well-formed requests: fill a free gap, touch or overlap one entry,
  // or bridge the narrowest gap so the table keeps its spread
  function automatic void pick_interval(output logic signed [VAL_W-1:0] a, b);
    longint lo_f, hi_f, s, e, w, g, best_gap;
    int     sel, k, j, m, best;
    logic signed [VAL_W-1:0] t;
    sel = $urandom_range(0, 99);
    w = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 1 << $urandom_range(4, 20)))
                                    : longint'($urandom_range(0, 15));
    if (sel < 25 && set_cnt >= 2) begin
      best = 0;
      best_gap = 0;
      for (j = 0; j < set_cnt - 1; j++) begin
        g = longint'(set_lo[j + 1]) - longint'(set_hi[j]);
        if (j == 0 || g < best_gap) begin
          best = j;
          best_gap = g;
        end
      end
      j = best;
      m = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : 1;
      if (j + m >= set_cnt) m = set_cnt - 1 - j;
      s = longint'(set_hi[j]) - rand_below(longint'(set_hi[j]) - longint'(set_lo[j]) + 1);
      e = longint'(set_lo[j + m])
          + rand_below(longint'(set_hi[j + m]) - longint'(set_lo[j + m]) + 1);
    end else if (sel < 50 && set_cnt >= 1) begin
      k = $urandom_range(0, set_cnt - 1);
      case (touch_e'($urandom_range(0, 2)))
        TOUCH_BELOW: begin
          e = longint'(set_lo[k]);
          s = e - w;
        end
        TOUCH_ABOVE: begin
          s = longint'(set_hi[k]);
          e = s + w;
        end
        default: begin
          s = longint'(set_lo[k])
              + rand_below(longint'(set_hi[k]) - longint'(set_lo[k]) + 1);
          e = s + w;
        end
      endcase
    end else begin
      k = $urandom_range(0, set_cnt);
      lo_f = (k == 0) ? VMIN_L : longint'(set_hi[k - 1]) + 1;
      hi_f = (k == set_cnt) ? VMAX_L : longint'(set_lo[k]) - 1;
      if (lo_f > hi_f) begin
        s = longint'(set_lo[0]);
        e = s;
      end else begin
        case ($urandom_range(0, 7))
          0:       s = lo_f;
          1:       s = hi_f;
          default: s = lo_f + rand_below(hi_f - lo_f + 1);
        endcase
        e = s + w;
        if (e > hi_f) e = hi_f;
      end
    end
    if (s < VMIN_L) s = VMIN_L;
    if (e > VMAX_L) e = VMAX_L;
    a = s[VAL_W-1:0];
    b = e[VAL_W-1:0];
    if ($urandom_range(0, 7) == 0) begin
      t = a;
      a = b;
      b = t;
    end
  endfunction

  task automatic send_req(input logic signed [VAL_W-1:0] a, b, input bit predicted);
    in_valid <= 1'b1;
    new_start <= a;
    new_end <= b;
    do @(posedge clk); while (!in_ready);
    insert_interval(a, b, predicted);
    n_reqs++;
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 45) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      new_start <= $urandom;
      new_end <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
  endtask

  initial begin
    dir_row_t row;
    logic signed [VAL_W-1:0] a, b;
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      send_req(row.a, row.b, !row.typed);
      if (row.typed)
        expect_seg('{row.t_lo, row.t_hi, '0, 1'b1, 1'b0});
      pace();
    end
    drain_all();
    for (i = 0; i < N_RAND; i++) begin
      if (i == 120) begin
        // long receiver hold-off while requests keep coming
        hold_req = 1'b1;
        burst_left = 40;
      end
      if (i == 240) drain_all();
      pick_interval(a, b);
      send_req(a, b, 1'b1);
      pace();
    end
    drain_all();
    repeat (2 * DEPTH + 8) @(posedge clk);
    $display("Ran %0d insert requests: %0d merged, %0d dropped on a full table.",
             n_reqs, n_merged, n_dropped);
    $display("Checked %0d emitted intervals, peak occupancy %0d of %0d, %0d mismatches.",
             n_segs, peak_cnt, DEPTH, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 299;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          rx_pat = rx_pat_e'($urandom_range(0, 3));
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        phase++;
        case (rx_pat)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= $urandom_range(0, 1);
          RX_SPARSE: out_ready <= (phase % 4 == 0);
          default:   out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    seg_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{seg_start, seg_end, slot, last_of_run, overflow};
      n_segs++;
      if (expected_segs.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected interval lo=%0d hi=%0d slot=%0d last=%0b ovf=%0b",
                   $realtime, got.lo, got.hi, got.pos, got.last, got.ovf);
      end else begin
        want = expected_segs.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $write("%0t: mismatch exp lo=%0d hi=%0d slot=%0d last=%0b ovf=%0b,",
                   $realtime, want.lo, want.hi, want.pos, want.last, want.ovf);
            $display(" got lo=%0d hi=%0d slot=%0d last=%0b ovf=%0b",
                     got.lo, got.hi, got.pos, got.last, got.ovf);
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
